// ===== src/assert_macros.svh =====
// assertion macros used by the rhythm generator datapath erg_dp
// no dependencies; clock and reset are passed in by the caller
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ERG_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, checked out of reset
`define ERG_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== src/erg_pkg.sv =====
// shared types, constants and helper functions of the rhythm generator
// used by erg_ctrl, erg_dp and the top level; no dependencies
package erg_pkg;

   localparam int PAT_W = 32;
   localparam int CNT_W = 6;
   localparam int ROT_W = 5;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_DIV,
      ST_EXP,
      ST_FIND,
      ST_ROT,
      ST_OUT
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_SETUP,
      OP_DIV_SUB,
      OP_DIV_NEXT,
      OP_DIV_END,
      OP_ERR,
      OP_EXP_REP,
      OP_EXP_FIN,
      OP_FIND,
      OP_ROT,
      OP_OUT
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic bad;       // input out of range
      logic special;   // no pulses or all pulses
      logic div_ge;    // dividend still at or above divisor
      logic div_last;  // remainder ends the euclid chain
      logic lvl_ovf;   // next division would overrun the level table
      logic rep;       // another repeat of the current piece
      logic last;      // current level is the top one
      logic out_free;  // output register can take an item
   } status_type;

   typedef struct packed {
      logic [PAT_W-1:0] word;
      logic [CNT_W-1:0] len;
   } append_type;

   // append a piece above the bits built so far, length saturating at 32
   function automatic append_type erg_append(input logic [PAT_W-1:0] word,
                                             input logic [CNT_W-1:0] len,
                                             input logic [PAT_W-1:0] piece,
                                             input logic [CNT_W-1:0] plen);
      logic [CNT_W:0] sum;
      append_type     r;
      sum    = {1'b0, len} + {1'b0, plen};
      r.word = word;
      if (len < CNT_W'(PAT_W)) begin
         r.word = word | (piece << len[ROT_W-1:0]);
      end
      r.len = (sum > (CNT_W+1)'(PAT_W)) ? CNT_W'(PAT_W) : sum[CNT_W-1:0];
      return r;
   endfunction

   // position of the lowest set bit, zero when none is set
   function automatic logic [ROT_W-1:0] erg_lowest_one(input logic [PAT_W-1:0] w);
      logic [ROT_W-1:0] f;
      f = '0;
      for (int i = PAT_W - 1; i >= 0; i--) begin
         if (w[i]) begin
            f = ROT_W'(i);
         end
      end
      return f;
   endfunction

endpackage

// ===== src/erg_ctrl.sv =====
// controller state machine of the rhythm generator
// depends on erg_pkg; drives datapath commands, reads datapath status
module erg_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  erg_pkg::status_type st,
   output erg_pkg::cmd_type    cmd
);

   erg_pkg::state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= erg_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      cmd.op     = erg_pkg::OP_NONE;
      req_tready = 1'b0;
      case (state_ff)
         erg_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.op   = erg_pkg::OP_LOAD;
               state_in = erg_pkg::ST_SETUP;
            end
         end
         erg_pkg::ST_SETUP: begin
            cmd.op = erg_pkg::OP_SETUP;
            if (st.bad || st.special) begin
               state_in = erg_pkg::ST_OUT;
            end else begin
               state_in = erg_pkg::ST_DIV;
            end
         end
         erg_pkg::ST_DIV: begin
            if (st.div_ge) begin
               cmd.op = erg_pkg::OP_DIV_SUB;
            end else if (st.div_last) begin
               cmd.op   = erg_pkg::OP_DIV_END;
               state_in = erg_pkg::ST_EXP;
            end else if (st.lvl_ovf) begin
               cmd.op   = erg_pkg::OP_ERR;
               state_in = erg_pkg::ST_OUT;
            end else begin
               cmd.op = erg_pkg::OP_DIV_NEXT;
            end
         end
         erg_pkg::ST_EXP: begin
            if (st.rep) begin
               cmd.op = erg_pkg::OP_EXP_REP;
            end else begin
               cmd.op = erg_pkg::OP_EXP_FIN;
               if (st.last) begin
                  state_in = erg_pkg::ST_FIND;
               end
            end
         end
         erg_pkg::ST_FIND: begin
            cmd.op   = erg_pkg::OP_FIND;
            state_in = erg_pkg::ST_ROT;
         end
         erg_pkg::ST_ROT: begin
            cmd.op   = erg_pkg::OP_ROT;
            state_in = erg_pkg::ST_OUT;
         end
         erg_pkg::ST_OUT: begin
            if (st.out_free) begin
               cmd.op   = erg_pkg::OP_OUT;
               state_in = erg_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = erg_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ===== src/erg_dp.sv =====
// datapath of the rhythm generator: euclid divider, level tables,
// piece expansion, rotation and output register; depends on erg_pkg
`include "assert_macros.svh"

module erg_dp #(
   parameter int MAX_SLOTS  = 32,
   parameter int MAX_LEVELS = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  erg_pkg::cmd_type                    cmd,
   output erg_pkg::status_type                 st,
   input  logic [erg_pkg::CNT_W-1:0]           in_slots,
   input  logic [erg_pkg::CNT_W-1:0]           in_pulses,
   input  logic [erg_pkg::ROT_W-1:0]           in_rot,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [erg_pkg::PAT_W-1:0]           out_pattern,
   output logic [erg_pkg::CNT_W-1:0]           out_length,
   output logic                                out_status
);

   localparam int LW = $clog2(MAX_LEVELS);
   localparam int PW = erg_pkg::PAT_W;
   localparam int CW = erg_pkg::CNT_W;
   localparam int RW = erg_pkg::ROT_W;

   // item registers
   logic [CW-1:0] slots_ff, slots_in;
   logic [CW-1:0] pulses_ff, pulses_in;
   logic [RW-1:0] rot_ff, rot_in;
   logic          inv_ff, inv_in;
   logic          err_ff, err_in;
   logic [PW-1:0] res_ff, res_in;
   // euclid divider
   logic [CW-1:0] div_ff, div_in;
   logic [CW-1:0] rem_ff, rem_in;
   logic [CW-1:0] q_ff, q_in;
   logic [LW-1:0] lv_ff, lv_in;
   // expansion
   logic [LW-1:0] l_ff, l_in;
   logic [CW-1:0] i_ff, i_in;
   logic [PW-1:0] prev_ff, prev_in, cur_ff, cur_in, acc_ff, acc_in;
   logic [CW-1:0] prev_len_ff, prev_len_in, cur_len_ff, cur_len_in;
   logic [CW-1:0] alen_ff, alen_in;
   logic [RW-1:0] k_ff, k_in;
   // level tables
   logic [CW-1:0] quot_ff [MAX_LEVELS];
   logic [CW-1:0] rest_ff [MAX_LEVELS];
   // output register
   logic          vld_ff, vld_in;
   logic [PW-1:0] opat_ff, opat_in;
   logic [CW-1:0] olen_ff, olen_in;
   logic          ost_ff, ost_in;

   logic [CW-1:0]  pulses_eff, quot_rd, rest_rd, mask_sh, rot_sh;
   logic [PW-1:0]  mask, piece_sel, fin_word;
   logic [CW-1:0]  piece_len, fin_len;
   logic [CW:0]    k_sum;
   logic [RW-1:0]  first;
   logic           inv_now, bad, zero, full;
   erg_pkg::append_type app;

   // input checks and complement selection
   always_comb begin
      inv_now    = {pulses_ff, 1'b0} > {1'b0, slots_ff};
      pulses_eff = inv_now ? (slots_ff - pulses_ff) : pulses_ff;
      bad  = (slots_ff == '0) || ({1'b0, slots_ff} > (CW+1)'(MAX_SLOTS)) ||
             (slots_ff > CW'(PW)) || (pulses_ff > slots_ff) ||
             ({1'b0, rot_ff} >= slots_ff);
      zero = (pulses_ff == '0);
      full = (pulses_ff == slots_ff);
      mask_sh = CW'(PW) - slots_ff;
      mask    = {PW{1'b1}} >> mask_sh[RW-1:0];
   end

   // level table reads and shared append
   assign quot_rd   = quot_ff[l_ff];
   assign rest_rd   = rest_ff[l_ff];
   assign piece_sel = (cmd.op == erg_pkg::OP_EXP_REP) ? cur_ff : prev_ff;
   assign piece_len = (cmd.op == erg_pkg::OP_EXP_REP) ? cur_len_ff : prev_len_ff;
   assign app       = erg_pkg::erg_append(acc_ff, alen_ff, piece_sel, piece_len);
   assign fin_word  = (rest_rd != '0) ? app.word : acc_ff;
   assign fin_len   = (rest_rd != '0) ? app.len : alen_ff;

   // first one and combined rotation
   assign first  = erg_pkg::erg_lowest_one(res_ff);
   assign k_sum  = {2'b00, first} + {2'b00, rot_ff};
   assign rot_sh = slots_ff - {1'b0, k_ff};

   // status to controller
   always_comb begin
      st.bad      = bad;
      st.special  = zero || full;
      st.div_ge   = div_ff >= rem_ff;
      st.div_last = div_ff <= CW'(1);
      st.lvl_ovf  = ({1'b0, lv_ff} + (LW+1)'(2)) >= (LW+1)'(MAX_LEVELS);
      st.rep      = (i_ff < quot_rd) && (alen_ff < CW'(PW));
      st.last     = (l_ff == lv_ff);
      st.out_free = !vld_ff || rsp_tready;
   end

   // next values
   always_comb begin
      slots_in = slots_ff;  pulses_in = pulses_ff;  rot_in = rot_ff;
      inv_in = inv_ff;  err_in = err_ff;  res_in = res_ff;
      div_in = div_ff;  rem_in = rem_ff;  q_in = q_ff;  lv_in = lv_ff;
      l_in = l_ff;  i_in = i_ff;  k_in = k_ff;
      prev_in = prev_ff;  cur_in = cur_ff;  acc_in = acc_ff;
      prev_len_in = prev_len_ff;  cur_len_in = cur_len_ff;  alen_in = alen_ff;
      opat_in = opat_ff;  olen_in = olen_ff;  ost_in = ost_ff;
      vld_in = vld_ff && !rsp_tready;
      case (cmd.op)
         erg_pkg::OP_LOAD: begin
            slots_in  = in_slots;
            pulses_in = in_pulses;
            rot_in    = in_rot;
         end
         erg_pkg::OP_SETUP: begin
            err_in = bad;
            res_in = (bad || zero) ? '0 : mask;
            inv_in = inv_now;
            div_in = slots_ff - pulses_eff;
            rem_in = pulses_eff;
            q_in   = '0;
            lv_in  = '0;
         end
         erg_pkg::OP_DIV_SUB: begin
            div_in = div_ff - rem_ff;
            q_in   = q_ff + CW'(1);
         end
         erg_pkg::OP_DIV_NEXT: begin
            div_in = rem_ff;
            rem_in = div_ff;
            q_in   = '0;
            lv_in  = lv_ff + LW'(1);
         end
         erg_pkg::OP_DIV_END: begin
            lv_in       = lv_ff + LW'(1);
            l_in        = '0;
            i_in        = '0;
            acc_in      = '0;
            alen_in     = '0;
            prev_in     = inv_ff ? '0 : PW'(1);
            cur_in      = inv_ff ? PW'(1) : '0;
            prev_len_in = CW'(1);
            cur_len_in  = CW'(1);
         end
         erg_pkg::OP_ERR: begin
            err_in = 1'b1;
            res_in = '0;
         end
         erg_pkg::OP_EXP_REP: begin
            acc_in  = app.word;
            alen_in = app.len;
            i_in    = i_ff + CW'(1);
         end
         erg_pkg::OP_EXP_FIN: begin
            prev_in     = cur_ff;
            prev_len_in = cur_len_ff;
            cur_in      = fin_word;
            cur_len_in  = fin_len;
            acc_in      = '0;
            alen_in     = '0;
            i_in        = '0;
            l_in        = l_ff + LW'(1);
            res_in      = fin_word & mask;
         end
         erg_pkg::OP_FIND: begin
            k_in = (k_sum >= {1'b0, slots_ff}) ? RW'(k_sum - {1'b0, slots_ff})
                                               : k_sum[RW-1:0];
         end
         erg_pkg::OP_ROT: begin
            if (k_ff != '0) begin
               res_in = ((res_ff >> k_ff) | (res_ff << rot_sh[RW-1:0])) & mask;
            end
         end
         erg_pkg::OP_OUT: begin
            vld_in  = 1'b1;
            opat_in = err_ff ? '0 : res_ff;
            olen_in = err_ff ? '0 : slots_ff;
            ost_in  = err_ff;
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      slots_ff <= slots_in;  pulses_ff <= pulses_in;  rot_ff <= rot_in;
      inv_ff <= inv_in;  err_ff <= err_in;  res_ff <= res_in;
      div_ff <= div_in;  rem_ff <= rem_in;  q_ff <= q_in;  lv_ff <= lv_in;
      l_ff <= l_in;  i_ff <= i_in;  k_ff <= k_in;
      prev_ff <= prev_in;  cur_ff <= cur_in;  acc_ff <= acc_in;
      prev_len_ff <= prev_len_in;  cur_len_ff <= cur_len_in;  alen_ff <= alen_in;
      opat_ff <= opat_in;  olen_ff <= olen_in;  ost_ff <= ost_in;
   end

   // level tables: quotient at the current level, remainder one above
   always_ff @(posedge clock) begin
      if (cmd.op == erg_pkg::OP_SETUP) begin
         rest_ff[0] <= pulses_eff;
      end
      if (cmd.op == erg_pkg::OP_DIV_NEXT || cmd.op == erg_pkg::OP_DIV_END) begin
         quot_ff[lv_ff]          <= q_ff;
         rest_ff[lv_ff + LW'(1)] <= div_ff;
      end
      if (cmd.op == erg_pkg::OP_DIV_END) begin
         quot_ff[lv_ff + LW'(1)] <= rem_ff;
      end
   end

   assign rsp_tvalid  = vld_ff;
   assign out_pattern = opat_ff;
   assign out_length  = olen_ff;
   assign out_status  = ost_ff;

   // error items carry no pattern and no length
   `ERG_ASSERT_NOW(a_err_empty, clock, reset, vld_ff && ost_ff,
                   opat_ff == '0 && olen_ff == '0)
   // each subtract step lowers the dividend
   `ERG_ASSERT_NEXT(a_div_falls, clock, reset, cmd.op == erg_pkg::OP_DIV_SUB,
                    div_ff < $past(div_ff))
   // combined rotation stays below the slot count
   `ERG_ASSERT_NEXT(a_rot_range, clock, reset, cmd.op == erg_pkg::OP_FIND,
                    {1'b0, k_ff} < slots_ff)

endmodule

// ===== src/euclidean_rhythm_generator.sv =====
// Euclidean rhythm generator: one request item (slot count, pulse count, offset) gives one
// response item holding the Bjorklund pattern; a request is taken only while the engine is
// idle, and a finished response waits in an output register so the next request can start.
// The euclid divider does one subtract a cycle for each unit of the euclid quotients, and the
// expander appends one piece a cycle across the levels while fewer than 32 bits are built.
// depends on erg_pkg, erg_ctrl and erg_dp
module euclidean_rhythm_generator #(
   parameter int MAX_SLOTS  = 32,
   parameter int MAX_LEVELS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // slot_count[5:0], pulse_count[11:6], rotate_by[16:12]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // pattern[31:0], pattern_length[37:32]
   output logic        rsp_tuser    // status
);

   erg_pkg::cmd_type    cmd;
   erg_pkg::status_type st;
   logic [erg_pkg::PAT_W-1:0] pattern;
   logic [erg_pkg::CNT_W-1:0] pattern_length;

   erg_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .st         (st),
      .cmd        (cmd)
   );

   erg_dp #(
      .MAX_SLOTS  (MAX_SLOTS),
      .MAX_LEVELS (MAX_LEVELS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .st          (st),
      .in_slots    (req_tdata[5:0]),
      .in_pulses   (req_tdata[11:6]),
      .in_rot      (req_tdata[16:12]),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .out_pattern (pattern),
      .out_length  (pattern_length),
      .out_status  (rsp_tuser)
   );

   // response packing
   assign rsp_tdata = {2'b00, pattern_length, pattern};

endmodule
